[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/cltok_pkg.sv]
`default_nettype none

package cltok_pkg;

    localparam int LINE_SIZE_DEF = 128;
    localparam int MAX_ARGS_DEF  = 16;

    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 7;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_UNCLOSED = 2'd1,
        ST_TOO_MANY = 2'd2
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  arg_count;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  arg_index;
        logic [ADDR_W-1:0]   arg_addr;
        logic [CHAR_W-1:0]   write_data;
        logic [ADDR_W-1:0]   write_addr;
    } result_t;

endpackage

`default_nettype wire

[hdl/command_line_tokenizer_top.sv]
// Channel  Dir  tdata                 tuser                     tlast
// s_axis   in   char_in[7:0]          -                         last_in
// m_axis   out  result_t, padded to 40 bits  write_valid, arg_begin  line_done
//
// Two register stages: an input register, then the result register.
// One item per cycle sustained while m_tready stays high; the tokenizer state
// update is the only loop and closes through its state registers.
// rst_n clears all tokenizer state and both valid flags.
// A stalled result holds a full input register, which drops s_tready.
`default_nettype none

module command_line_tokenizer_top
#(
    parameter int LINE_SIZE = cltok_pkg::LINE_SIZE_DEF,
    parameter int MAX_ARGS  = cltok_pkg::MAX_ARGS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // char_in[7:0]
    input  wire logic                                s_tlast,  // last_in
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // write_addr[6:0], write_data[14:7], arg_addr[21:15], arg_index[25:22],
    // status[27:26], arg_count[32:28], zero[39:33]
    output logic [cltok_pkg::OUT_DATA_W-1:0]         m_tdata,
    // write_valid[0], arg_begin[1]
    output logic [cltok_pkg::OUT_USER_W-1:0]         m_tuser,
    output logic                                     m_tlast   // line_done
);
    import cltok_pkg::*;

    localparam int WP_W  = $clog2(LINE_SIZE + 1);
    localparam int CNT_W = $clog2(MAX_ARGS + 1);

    // input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // tokenizer state
    logic              inside_arg_reg,  inside_arg_next;
    logic              inside_quote_reg, inside_quote_next;
    logic [CHAR_W-1:0] prev_byte_reg,   prev_byte_next;
    logic [WP_W-1:0]   write_pos_reg,   write_pos_next;
    logic [CNT_W-1:0]  arg_total_reg,   arg_total_next;
    logic              line_fin_reg,    line_fin_next;
    logic              too_many_reg,    too_many_next;

    // result register
    logic              out_valid_reg;
    result_t           out_data_reg, out_data_next;
    logic              out_wvalid_reg, out_wvalid_next;
    logic              out_abegin_reg, out_abegin_next;
    logic              out_done_reg,   out_done_next;

    logic out_free;
    logic process;

    assign out_free = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        logic              ia, iq, tm, term, esc;
        logic [CHAR_W-1:0] pb, c, data;
        logic [WP_W-1:0]   wp;
        logic [CNT_W-1:0]  tot;
        logic              start_arg;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] addr;
        logic              advance;

        c    = in_char_reg;
        term = (c == CH_NUL) || in_last_reg;

        // a closed line starts the next item from cleared state
        ia  = line_fin_reg ? 1'b0 : inside_arg_reg;
        iq  = line_fin_reg ? 1'b0 : inside_quote_reg;
        pb  = line_fin_reg ? CH_NUL : prev_byte_reg;
        wp  = line_fin_reg ? '0 : write_pos_reg;
        tot = line_fin_reg ? '0 : arg_total_reg;
        tm  = line_fin_reg ? 1'b0 : too_many_reg;

        out_data_next   = '0;
        out_wvalid_next = 1'b0;
        out_abegin_next = 1'b0;
        start_arg       = 1'b0;
        start_addr      = ADDR_W'(wp);
        data            = c;
        addr            = ADDR_W'(wp);
        advance         = 1'b1;
        esc             = ((c == CH_QUOTE) || (c == CH_SPACE)) && ia
                          && (pb == CH_BACKSLASH) && (wp != '0);

        if (wp < WP_W'(LINE_SIZE))
        begin
            priority if (esc)
            begin
                addr    = ADDR_W'(wp - WP_W'(1));
                advance = 1'b0;
            end
            else if (c == CH_QUOTE)
            begin
                if (!ia)
                begin
                    ia         = 1'b1;
                    iq         = 1'b1;
                    start_arg  = 1'b1;
                    start_addr = ADDR_W'(wp) + ADDR_W'(1);
                end
                else if (iq)
                begin
                    ia   = 1'b0;
                    iq   = 1'b0;
                    data = CH_NUL;
                end
            end
            else if (c == CH_SPACE)
            begin
                if (ia && !iq)
                begin
                    ia   = 1'b0;
                    data = CH_NUL;
                end
            end
            else
            begin
                if ((c != CH_NUL) && !ia)
                begin
                    ia        = 1'b1;
                    start_arg = 1'b1;
                end
            end

            if (start_arg)
            begin
                if (tot < CNT_W'(MAX_ARGS))
                begin
                    out_abegin_next         = 1'b1;
                    out_data_next.arg_addr  = start_addr;
                    out_data_next.arg_index = INDEX_W'(tot);
                    tot                     = tot + CNT_W'(1);
                end
                else
                begin
                    tm = 1'b1;
                end
            end

            out_wvalid_next          = 1'b1;
            out_data_next.write_addr = addr;
            out_data_next.write_data = data;
            pb                       = data;
            wp                       = wp + WP_W'(advance);
        end

        out_done_next = term;
        if (term)
        begin
            priority if (iq)
                out_data_next.status = ST_UNCLOSED;
            else if (tm)
                out_data_next.status = ST_TOO_MANY;
            else
                out_data_next.status = ST_OK;
            out_data_next.arg_count = COUNT_W'(tot);
        end

        inside_arg_next   = ia;
        inside_quote_next = iq;
        prev_byte_next    = pb;
        write_pos_next    = wp;
        arg_total_next    = tot;
        too_many_next     = tm;
        line_fin_next     = term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            inside_arg_reg   <= 1'b0;
            inside_quote_reg <= 1'b0;
            prev_byte_reg    <= CH_NUL;
            write_pos_reg    <= '0;
            arg_total_reg    <= '0;
            line_fin_reg     <= 1'b0;
            too_many_reg     <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (process)
                in_valid_reg <= 1'b0;

            if (process)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (process)
            begin
                inside_arg_reg   <= inside_arg_next;
                inside_quote_reg <= inside_quote_next;
                prev_byte_reg    <= prev_byte_next;
                write_pos_reg    <= write_pos_next;
                arg_total_reg    <= arg_total_next;
                line_fin_reg     <= line_fin_next;
                too_many_reg     <= too_many_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (process)
        begin
            out_data_reg   <= out_data_next;
            out_wvalid_reg <= out_wvalid_next;
            out_abegin_reg <= out_abegin_next;
            out_done_reg   <= out_done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);
    assign m_tuser  = {out_abegin_reg, out_wvalid_reg};
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire

[hdl/cltok_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module cltok_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import cltok_pkg::*;

    logic [42:0] out_bundle;

    assign out_bundle = {m_tlast, m_tuser, m_tdata};

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(out_bundle))
    // an argument start always comes with a buffer write
    `ASSERT_IMPLIES(a_begin_has_write, clk, rst_n, m_tvalid && m_tuser[1], m_tuser[0])
    // unused write fields are zero
    `ASSERT_IMPLIES(a_write_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata[14:0] == 15'd0)
    // status and count only on the closing item
    `ASSERT_IMPLIES(a_close_zero, clk, rst_n, m_tvalid && !m_tlast, m_tdata[32:26] == 7'd0)
    // status never carries the unused code
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, m_tvalid, m_tdata[27:26] != 2'd3)

endmodule

bind command_line_tokenizer_top cltok_checker u_cltok_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import cltok_pkg::*;

    localparam int LINE_SIZE = 128;
    localparam int MAX_ARGS  = 16;

    typedef struct {
        logic       write_valid;
        logic [6:0] write_addr;
        logic [7:0] write_data;
        logic       arg_begin;
        logic [6:0] arg_addr;
        logic [3:0] arg_index;
        logic       line_done;
        status_t    status;
        logic [4:0] arg_count;
    } token_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    token_result_t expected_tokens[$];
    int          fail_count;
    bit          source_steady;
    bit          sink_steady;

    // tokenizer state mirror
    bit          in_arg;
    bit          in_quote;
    logic [7:0]  prev_byte;
    int          wpos;
    int          arg_total;
    bit          line_closed;
    bit          too_many;

    command_line_tokenizer_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void clear_line();
        in_arg      = 0;
        in_quote    = 0;
        prev_byte   = CH_NUL;
        wpos        = 0;
        arg_total   = 0;
        line_closed = 0;
        too_many    = 0;
    endfunction

    function automatic void open_arg(input int pos, inout token_result_t e);
        if (arg_total < MAX_ARGS)
        begin
            e.arg_begin = 1'b1;
            e.arg_addr  = 7'(pos);
            e.arg_index = 4'(arg_total);
            arg_total++;
        end
        else
            too_many = 1;
    endfunction

    function automatic token_result_t predict_token(input logic [7:0] c, input logic last);
        token_result_t e;
        bit            term;
        logic [6:0]    addr;
        logic [7:0]    data;
        int            adv;
        e = '{write_valid: 1'b0, write_addr: '0, write_data: '0, arg_begin: 1'b0,
              arg_addr: '0, arg_index: '0, line_done: 1'b0, status: ST_OK, arg_count: '0};
        term = (c == CH_NUL) || last;
        if (line_closed)
            clear_line();
        if (wpos < LINE_SIZE)
        begin
            addr = 7'(wpos);
            data = c;
            adv  = 1;
            if ((c == CH_QUOTE || c == CH_SPACE) && in_arg && prev_byte == CH_BACKSLASH
                && wpos > 0)
            begin
                addr = 7'(wpos - 1);
                adv  = 0;
            end
            else if (c == CH_QUOTE)
            begin
                if (!in_arg)
                begin
                    in_arg   = 1;
                    in_quote = 1;
                    open_arg(wpos + 1, e);
                end
                else if (in_quote)
                begin
                    in_arg   = 0;
                    in_quote = 0;
                    data     = CH_NUL;
                end
            end
            else if (c == CH_SPACE)
            begin
                if (in_arg && !in_quote)
                begin
                    in_arg = 0;
                    data   = CH_NUL;
                end
            end
            else if (c != CH_NUL)
            begin
                if (!in_arg)
                begin
                    in_arg = 1;
                    open_arg(wpos, e);
                end
            end
            e.write_valid = 1'b1;
            e.write_addr  = addr;
            e.write_data  = data;
            prev_byte     = data;
            wpos          = wpos + adv;
        end
        if (term)
        begin
            e.line_done = 1'b1;
            if (in_quote)
                e.status = ST_UNCLOSED;
            else if (too_many)
                e.status = ST_TOO_MANY;
            else
                e.status = ST_OK;
            e.arg_count = 5'(arg_total);
            line_closed = 1;
        end
        return e;
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = source_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        expected_tokens.push_back(predict_token(c, last));
    endtask

    task automatic send_text(input string s, input bit close_with_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close_with_last && (i == s.len() - 1));
    endtask

    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // result side: random stalls, compare against oldest prediction
    initial
    begin
        token_result_t e;
        result_t       r;
        int            gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_steady = !sink_steady;
            gap = sink_steady ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            r = m_tdata[32:0];
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected item, actual tdata %h tuser %b tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                fail_count++;
            end
            else
            begin
                e = expected_tokens.pop_front();
                check_field("write_valid", int'(e.write_valid), int'(m_tuser[0]));
                check_field("write_addr", int'(e.write_addr), int'(r.write_addr));
                check_field("write_data", int'(e.write_data), int'(r.write_data));
                check_field("arg_begin", int'(e.arg_begin), int'(m_tuser[1]));
                check_field("arg_addr", int'(e.arg_addr), int'(r.arg_addr));
                check_field("arg_index", int'(e.arg_index), int'(r.arg_index));
                check_field("line_done", int'(e.line_done), int'(m_tlast));
                check_field("status", int'(e.status), int'(r.status));
                check_field("arg_count", int'(e.arg_count), int'(r.arg_count));
                check_field("tdata pad", 0, int'(m_tdata[39:33]));
            end
        end
    end

    // quotes, escapes, terminators, byte extremes
    task automatic test_directed();
        send_text("ab \"c d\"", 0);
        send_text(" e\\ f\\\"g\"h", 0);
        send_byte(8'hFF, 0);
        send_byte(CH_NUL, 0);
        send_text("\\\"", 1);
        send_text("\"k\\\"", 0);
        send_byte(CH_NUL, 0);
        send_byte(8'hFF, 1);
        send_byte(CH_NUL, 0);
        send_text("  \"\" x", 1);
    endtask

    task automatic test_too_many();
        for (int i = 0; i <= MAX_ARGS + 1; i++)
            send_text("w ", 0);
        send_byte("z", 1);
        for (int i = 0; i <= MAX_ARGS; i++)
            send_text("v ", 0);
        send_text("\"q", 0);
        send_byte(CH_NUL, 0);
    endtask

    task automatic test_full_store();
        for (int i = 0; i < LINE_SIZE + 12; i++)
            send_byte(8'($urandom_range(8'h21, 8'h7E)), i == LINE_SIZE + 11);
        for (int i = 0; i < LINE_SIZE + 3; i++)
            send_byte((i % 5 == 4) ? CH_SPACE : 8'($urandom_range(1, 255)), 0);
        send_byte(CH_NUL, 0);
    endtask

    function automatic logic [7:0] line_byte(input bit words_only);
        int r;
        r = $urandom_range(0, 99);
        if (words_only)
            return (r < 45) ? CH_SPACE : 8'($urandom_range("a", "z"));
        if (r < 15)
            return CH_SPACE;
        if (r < 25)
            return CH_QUOTE;
        if (r < 33)
            return CH_BACKSLASH;
        if (r < 40)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range("a", "z"));
    endfunction

    task automatic test_random();
        int sent;
        int len;
        int kind;
        bit words_only;
        logic [7:0] c;
        sent = 0;
        while (sent < 820)
        begin
            source_steady = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            words_only = (kind >= 80 && kind < 90);
            if (kind < 8)
                len = $urandom_range(LINE_SIZE - 4, LINE_SIZE + 10);
            else if (words_only)
                len = $urandom_range(20, 50);
            else
                len = $urandom_range(1, 30);
            for (int i = 0; i < len - 1; i++)
            begin
                c = (kind >= 95) ? 8'($urandom_range(0, 255)) : line_byte(words_only);
                send_byte(c, (kind >= 95) && ($urandom_range(0, 15) == 0));
            end
            if ($urandom_range(0, 1))
                send_byte(CH_NUL, 1'($urandom_range(0, 1)));
            else
                send_byte(line_byte(words_only), 1'b1);
            sent += len;
        end
        source_steady = 0;
    endtask

    initial
    begin
        fail_count    = 0;
        source_steady = 0;
        sink_steady   = 0;
        clear_line();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_too_many();
        test_full_store();
        test_random();
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule
